FILE: rtl/core/byte_signature_scanner_top_macros.svh
// Assertion macros for the byte signature scanner.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BYTE_SIGNATURE_SCANNER_TOP_MACROS_SVH
`define BYTE_SIGNATURE_SCANNER_TOP_MACROS_SVH

// Property that must hold in the same cycle.
`define BSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bss_pkg.sv
// Shared types and constants of the byte signature scanner.
// No dependencies.
package bss_pkg;

  localparam int SIG_LEN  = 16;
  localparam int MAX_SIGS = 16;

  localparam int ACT_W  = 5;
  localparam int SLOT_W = 4;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 16;

  localparam logic       ACT_SCAN  = 1'b0;
  localparam logic       ACT_LOAD  = 1'b1;
  localparam logic [31:0] ELF_MAGIC = 32'h7F45_4C46;
  localparam logic [31:0] PE_MAGIC  = 32'h4D5A_4000;

  typedef struct packed {
    logic              action;
    logic [7:0]        data_byte;
    logic [SLOT_W-1:0] sig_index;
    logic [POS_W-1:0]  sig_byte_pos;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic             is_executable;
    logic             virus_found;
    logic [CNT_W-1:0] infected_count;
  } out_t;

  // broadcast to every cell and the header checker
  typedef struct packed {
    logic              scan;
    logic              clear;
    logic              load;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [7:0]        data;
  } cell_ctl_t;

endpackage

FILE: rtl/core/bss_if.sv
// Valid/ready channel interfaces of the byte signature scanner.
// Depends on bss_pkg.
interface bss_in_if;
  logic         valid;
  logic         ready;
  bss_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bss_out_if;
  logic          valid;
  logic          ready;
  bss_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/bss_cell.sv
// One window position: holds that byte of every signature and the window
// byte handed on to the next cell on each scan beat. Depends on bss_pkg.
module bss_cell #(
  parameter int MaxSigs = bss_pkg::MAX_SIGS,
  parameter int CellIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bss_pkg::cell_ctl_t   ctl_i,
  input  logic [7:0]           byte_i,
  input  logic                 vld_i,
  output logic [7:0]           byte_o,
  output logic                 vld_o,
  output logic [MaxSigs-1:0]   eq_o
);

  localparam int SlotW = (MaxSigs > 1) ? $clog2(MaxSigs) : 1;

  logic [7:0]         sig_q [MaxSigs];
  logic [7:0]         byte_q;
  logic               vld_q;
  logic               wr_en;

  assign wr_en = ctl_i.load && (int'(ctl_i.pos) == CellIdx) && (int'(ctl_i.slot) < MaxSigs);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sig_q[SlotW'(ctl_i.slot)] <= ctl_i.data;
    end
  end

  // compare the byte arriving at this position against every signature
  always_comb begin
    for (int s = 0; s < MaxSigs; s++) begin
      eq_o[s] = vld_i && (sig_q[s] == byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      vld_q  <= 1'b0;
    end else if (ctl_i.scan) begin
      byte_q <= ctl_i.clear ? '0 : byte_i;
      vld_q  <= ctl_i.clear ? 1'b0 : vld_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;

endmodule

FILE: rtl/core/bss_hdr.sv
// Header capture and ELF/PE check over the first four bytes of a file.
// Depends on bss_pkg.
module bss_hdr (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bss_pkg::cell_ctl_t ctl_i,
  output logic               exec_o
);

  logic [31:0] hdr_d, hdr_q;
  logic [2:0]  cnt_d, cnt_q;

  always_comb begin
    hdr_d = hdr_q;
    cnt_d = cnt_q;
    if (cnt_q < 3'd4) begin
      hdr_d = {hdr_q[23:0], ctl_i.data};
      cnt_d = cnt_q + 3'd1;
    end
  end

  assign exec_o = (cnt_d == 3'd4) &&
                  ((hdr_d == bss_pkg::ELF_MAGIC) || (hdr_d == bss_pkg::PE_MAGIC));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.scan) begin
      if (ctl_i.clear) begin
        hdr_q <= '0;
        cnt_q <= '0;
      end else begin
        hdr_q <= hdr_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

FILE: rtl/core/byte_signature_scanner_top.sv
// Byte signature scanner: takes one beat per clock, load or scan, with no stall
// while fewer than two file results wait at the output. A file result appears in
// the output register the cycle after its final beat; a second one is held in a
// skid stage. The row of SIG_LEN cells holds the byte window, shifting one place
// per scan beat, and compares it against every signature at once.
// Depends on bss_pkg, bss_if, bss_cell, bss_hdr and the assertion macro header.
`include "byte_signature_scanner_top_macros.svh"

module byte_signature_scanner_top #(
  parameter int SigLen  = bss_pkg::SIG_LEN,
  parameter int MaxSigs = bss_pkg::MAX_SIGS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bss_pkg::ACT_W-1:0] cfg_wdata_i,
  bss_in_if.sink                    scan_i,
  bss_out_if.source                 res_o
);

  logic                      accept, push, pop;
  bss_pkg::cell_ctl_t        ctl;
  logic [bss_pkg::ACT_W-1:0] active_q;
  logic [MaxSigs-1:0]        act_mask;
  logic [7:0]                cell_byte [SigLen];
  logic                      cell_vld  [SigLen];
  logic [MaxSigs-1:0]        cell_eq   [SigLen];
  logic [MaxSigs-1:0]        all_eq;
  logic                      hit, exec, virus, seen_q;
  logic [bss_pkg::CNT_W-1:0] infected_d, infected_q;
  bss_pkg::out_t             res_new, out_q, skid_q;
  logic                      out_valid_q, skid_valid_q;

  assign scan_i.ready = !skid_valid_q;
  assign accept       = scan_i.valid && scan_i.ready;

  assign ctl.scan  = accept && (scan_i.data.action == bss_pkg::ACT_SCAN);
  assign ctl.load  = accept && (scan_i.data.action == bss_pkg::ACT_LOAD);
  assign ctl.clear = scan_i.data.last_byte;
  assign ctl.slot  = scan_i.data.sig_index;
  assign ctl.pos   = scan_i.data.sig_byte_pos;
  assign ctl.data  = scan_i.data.data_byte;

  assign push = ctl.scan && ctl.clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int s = 0; s < MaxSigs; s++) begin
      act_mask[s] = (s < int'(active_q));
    end
  end

  // newest byte enters the last cell, the oldest leaves cell 0
  for (genvar j = 0; j < SigLen; j++) begin : g_cell
    bss_cell #(
      .MaxSigs (MaxSigs),
      .CellIdx (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .byte_i ((j == SigLen-1) ? ctl.data : cell_byte[(j == SigLen-1) ? j : j+1]),
      .vld_i  ((j == SigLen-1) ? 1'b1 : cell_vld[(j == SigLen-1) ? j : j+1]),
      .byte_o (cell_byte[j]),
      .vld_o  (cell_vld[j]),
      .eq_o   (cell_eq[j])
    );
  end

  bss_hdr u_hdr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .exec_o (exec)
  );

  always_comb begin
    all_eq = act_mask;
    for (int j = 0; j < SigLen; j++) begin
      all_eq = all_eq & cell_eq[j];
    end
  end

  assign hit   = |all_eq;
  assign virus = exec && (seen_q || hit);

  always_comb begin
    infected_d = infected_q;
    if (virus && (infected_q != {bss_pkg::CNT_W{1'b1}})) begin
      infected_d = infected_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      infected_q <= '0;
    end else if (ctl.scan) begin
      seen_q <= ctl.clear ? 1'b0 : (seen_q || hit);
      if (ctl.clear) begin
        infected_q <= infected_d;
      end
    end
  end

  assign res_new.is_executable  = exec;
  assign res_new.virus_found    = virus;
  assign res_new.infected_count = infected_d;

  // output register plus skid stage
  assign pop = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  `BSS_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full with output empty")
  `BSS_ASSERT_NEXT(a_push_lands, push, out_valid_q, "file result lost")
  `BSS_ASSERT_NEXT(a_row_cleared, push, !cell_vld[0] && cell_byte[0] == '0, "window not cleared")
  `BSS_ASSERT(a_count_moves_on_push, (infected_q == $past(infected_q)) || $past(push),
              "infected count changed outside a final beat")

endmodule
